/* rtl/four_channel_trigger_pulse_control_defines.svh */
`ifndef FOUR_CHANNEL_TRIGGER_PULSE_CONTROL_DEFINES_SVH
`define FOUR_CHANNEL_TRIGGER_PULSE_CONTROL_DEFINES_SVH

// same-cycle implication, reset disables
`define FCTP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset disables
`define FCTP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/fctp_pkg.sv */
`default_nettype none

package fctp_pkg;

  localparam int CHANNELS_DEF   = 4;
  localparam int NUM_WIDTH_REGS = 4;
  localparam int NUM_REGS       = 1 + NUM_WIDTH_REGS;
  localparam int CMD_W          = 2;
  localparam int CH_W           = 2;
  localparam int MODE_W         = 2;
  localparam int WIDTH_W        = 10;
  localparam int FLAGS_W        = 4;
  localparam int TIME_W         = 32;
  localparam int MS_PER_UNIT    = 100;
  localparam int UNIT_W         = 7;
  localparam int LIMIT_W        = WIDTH_W + UNIT_W;
  localparam int CFG_DW         = 32;
  localparam int CFG_AW         = 5;
  localparam int REG_IDX_W      = CFG_AW - 2;

  localparam logic [REG_IDX_W-1:0] REG_OP_MODE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH_CH0 = 3'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_TRIGGER = 2'd1,
    CMD_REINIT  = 2'd2
  } cmd_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALL_ON = 2'd0,
    MODE_LEVEL  = 2'd1,
    MODE_PULSE  = 2'd2
  } op_mode_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [CH_W-1:0]  channel;
    logic             level;
  } in_item_t;

  typedef struct packed {
    logic [FLAGS_W-1:0] led_enable;
    logic [FLAGS_W-1:0] pulse_busy;
  } out_item_t;

  typedef struct packed {
    logic [MODE_W-1:0]                      op_mode;
    logic [NUM_WIDTH_REGS-1:0][WIDTH_W-1:0] width;
  } cfg_regs_t;

endpackage

`default_nettype wire

/* rtl/four_channel_trigger_pulse_control.sv */
// Channel | Direction | Handshake        | Payload
// in_     | input     | valid / stall    | in_item_t: command, channel, level
// out_    | output    | valid / stall    | out_item_t: led_enable, pulse_busy
// cfg_    | input     | APB write / read | op_mode, width_ch0..width_ch3
//
// Each transaction passes from input to result through the input register, then
// state update and result register in the same edge. One transaction per cycle
// unless the result stalls. The per-channel expiry compare is a wrapping subtract
// against width * 100. Synchronous active-low reset clears control state and flags.
// A stalled result holds; the input register holds behind it, then in_stall rises.
`default_nettype none

`include "four_channel_trigger_pulse_control_defines.svh"

module four_channel_trigger_pulse_control
  import fctp_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  localparam logic [CHANNELS-1:0] ALL_MASK = '1;

  cfg_regs_t                         regs;
  op_mode_t                          mode;
  cmd_t                              cmd;

  logic                              in_valid_r;
  in_item_t                          in_r;
  logic                              out_valid_r;
  out_item_t                         out_r;
  out_item_t                         out_nxt;
  logic                              proc_fire;

  logic [TIME_W-1:0]                 now_r;
  logic [TIME_W-1:0]                 now_nxt;
  logic [TIME_W-1:0]                 now_inc;
  logic [CHANNELS-1:0][TIME_W-1:0]   start_r;
  logic [CHANNELS-1:0][TIME_W-1:0]   start_nxt;
  logic [CHANNELS-1:0]               busy_r;
  logic [CHANNELS-1:0]               busy_nxt;
  logic [CHANNELS-1:0]               enable_r;
  logic [CHANNELS-1:0]               enable_nxt;
  logic                              done_r;
  logic                              done_nxt;

  logic [CHANNELS-1:0][WIDTH_W-1:0]  chan_width;
  logic [CHANNELS-1:0]               expired;
  logic [CHANNELS-1:0]               ch_hit;
  logic [FLAGS_W-1:0]                out_all;

  fctp_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .regs        (regs)
  );

  assign mode      = op_mode_t'(regs.op_mode);
  assign cmd       = cmd_t'(in_r.command);
  assign proc_fire = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !proc_fire;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign now_inc   = now_r + TIME_W'(1);

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    logic [LIMIT_W-1:0] limit;
    logic [TIME_W-1:0]  elapsed;
    if (c < NUM_WIDTH_REGS) begin : g_cfg
      assign chan_width[c] = regs.width[c];
    end else begin : g_zero
      assign chan_width[c] = '0;
    end
    assign limit      = LIMIT_W'(chan_width[c]) * LIMIT_W'(MS_PER_UNIT);
    assign elapsed    = now_inc - start_r[c];
    assign expired[c] = (chan_width[c] == '0) || (elapsed >= TIME_W'(limit));
    assign ch_hit[c]  = (int'(in_r.channel) == c);
  end

  always_comb begin
    enable_nxt = enable_r;
    busy_nxt   = busy_r;
    done_nxt   = done_r;
    now_nxt    = now_r;
    start_nxt  = start_r;
    case (cmd)
      CMD_TICK: begin
        now_nxt = now_inc;
        case (mode)
          MODE_ALL_ON: begin
            if (!done_r) begin
              enable_nxt = ALL_MASK;
              busy_nxt   = '0;
              done_nxt   = 1'b1;
            end
          end
          MODE_LEVEL: begin
            done_nxt = 1'b0;
          end
          MODE_PULSE: begin
            for (int c = 0; c < CHANNELS; c++) begin
              if (busy_r[c] && expired[c]) begin
                enable_nxt[c] = 1'b0;
                busy_nxt[c]   = 1'b0;
              end
            end
            done_nxt = 1'b0;
          end
          default: begin
          end
        endcase
      end
      CMD_TRIGGER: begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (ch_hit[c]) begin
            case (mode)
              MODE_LEVEL: begin
                enable_nxt[c] = in_r.level;
              end
              MODE_PULSE: begin
                if (in_r.level && !busy_r[c] && (chan_width[c] != '0)) begin
                  enable_nxt[c] = 1'b1;
                  busy_nxt[c]   = 1'b1;
                  start_nxt[c]  = now_r;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      CMD_REINIT: begin
        case (mode)
          MODE_LEVEL: busy_nxt = '0;
          MODE_PULSE: busy_nxt = ALL_MASK;
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_nxt = '0;
    out_all = '0;
    for (int b = 0; b < FLAGS_W; b++) begin
      if (b < CHANNELS) begin
        out_nxt.led_enable[b] = enable_nxt[b];
        out_nxt.pulse_busy[b] = busy_nxt[b];
        out_all[b]            = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      now_r       <= '0;
      start_r     <= '0;
      busy_r      <= '0;
      enable_r    <= '0;
      done_r      <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        in_valid_r <= 1'b1;
      end else if (proc_fire) begin
        in_valid_r <= 1'b0;
      end
      if (proc_fire) begin
        out_valid_r <= 1'b1;
        now_r       <= now_nxt;
        start_r     <= start_nxt;
        busy_r      <= busy_nxt;
        enable_r    <= enable_nxt;
        done_r      <= done_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
    if (proc_fire) begin
      out_r <= out_nxt;
    end
  end

  `FCTP_ASSERT_NEXT(a_no_bubble, in_valid_r && !out_valid_r, out_valid_r,
                    "pending transaction not moved to result register")
  `FCTP_ASSERT_NEXT(a_tick_advances, proc_fire && (cmd == CMD_TICK),
                    now_r == $past(now_r) + TIME_W'(1), "tick did not advance time by one")
  `FCTP_ASSERT_NEXT(a_always_on,
                    proc_fire && (cmd == CMD_TICK) && (mode == MODE_ALL_ON) && !done_r,
                    out_valid_r && (out_r.led_enable == out_all) && (out_r.pulse_busy == '0),
                    "always-on tick did not enable all channels")

endmodule

`default_nettype wire

/* rtl/fctp_regs.sv */
`default_nettype none

module fctp_regs
  import fctp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready,
  output cfg_regs_t              regs
);

  cfg_regs_t             regs_r;
  cfg_regs_t             regs_nxt;
  logic [REG_IDX_W-1:0]  idx;
  logic                  wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[CFG_AW-1:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign regs       = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      if (idx == REG_OP_MODE) begin
        regs_nxt.op_mode = cfg_pwdata[MODE_W-1:0];
      end
      for (int i = 0; i < NUM_WIDTH_REGS; i++) begin
        if (idx == REG_WIDTH_CH0 + REG_IDX_W'(i)) begin
          regs_nxt.width[i] = cfg_pwdata[WIDTH_W-1:0];
        end
      end
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (idx == REG_OP_MODE) begin
      cfg_prdata = CFG_DW'(regs_r.op_mode);
    end
    for (int i = 0; i < NUM_WIDTH_REGS; i++) begin
      if (idx == REG_WIDTH_CH0 + REG_IDX_W'(i)) begin
        cfg_prdata = CFG_DW'(regs_r.width[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

`default_nettype wire
